@@ hw/rtl/b85se_pkg.sv @@
// ----------------------------------------------------------------------------
// b85se_pkg
// Shared types, constants and the digit alphabet for the base-85 stream
// encoder.
// ----------------------------------------------------------------------------
package b85se_pkg;

    // Digits per encoded group and width of a digit index
    localparam int NumDigits = 5;
    localparam int DigitIdxW = 3;

    // Default depth of the job queue between front and back
    localparam int QueueDepthDefault = 2;

    // Character emitted for an all-zero complete group
    localparam logic [6:0] DotChar = 7'h2E;

    // Digit alphabet, first character in the top byte
    localparam logic [85*8-1:0] Alphabet =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz!#$%&()*+-;<=>?@^_`{|}~";

    // One group ready for conversion
    typedef struct packed {
        logic [31:0]          word;    // left-aligned, zero-padded group
        logic [DigitIdxW-1:0] count;   // characters to emit (1..5)
        logic                 dot;     // emit the zero-group shortcut
        logic                 eom;     // group closes the message
    } t_job;

    // Map a digit value (0..84) to its ASCII code
    function automatic logic [6:0] b85_char(input logic [6:0] digit);
        logic [7:0] c;
        c = 8'd0;
        if (digit < 7'd85) begin
            c = Alphabet[8*(84 - int'(digit)) +: 8];
        end
        return c[6:0];
    endfunction

endpackage

@@ hw/rtl/b85se_if.sv @@
// ----------------------------------------------------------------------------
// b85se_if
// Valid/ready channels of the encoder: byte input and character output.
// ----------------------------------------------------------------------------
interface b85se_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source(output valid, output data_byte, output end_of_message, input ready);
    modport sink(input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b85se_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       run_last;
    logic       message_done;

    modport source(output valid, output out_char, output run_last, output message_done,
                   input ready);
    modport sink(input valid, input out_char, input run_last, input message_done,
                 output ready);
endinterface

@@ hw/rtl/b85se_front.sv @@
// ----------------------------------------------------------------------------
// b85se_front
// Accepts message bytes, gathers them big-endian into groups and pushes a
// conversion job whenever a group completes or the message ends.
// ----------------------------------------------------------------------------
module b85se_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    b85se_byte_if.sink        i_byte,
    input  logic              i_q_full,
    output logic              o_q_push,
    output b85se_pkg::t_job   o_q_job
);
    import b85se_pkg::*;

    logic [23:0] r_held;
    logic [23:0] n_held;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        accept;
    logic        close;
    logic [31:0] raw_word;
    logic [4:0]  pad_sh;

    // Take a byte whenever the queue has room
    assign i_byte.ready = !i_q_full;
    assign accept       = i_byte.valid && !i_q_full;

    // A group closes on its fourth byte or at the end of the message
    assign close    = (r_cnt == 2'd3) || i_byte.end_of_message;
    assign raw_word = {r_held, i_byte.data_byte};
    assign pad_sh   = {3'(2'd3 - r_cnt), 2'b00} << 1;

    // Build the job for a closing group
    always_comb begin
        o_q_push      = accept && close;
        o_q_job.word  = raw_word << pad_sh;
        o_q_job.eom   = i_byte.end_of_message;
        if (r_cnt == 2'd3) begin
            o_q_job.dot   = (raw_word == 32'd0);
            o_q_job.count = (raw_word == 32'd0) ? DigitIdxW'(1) : DigitIdxW'(NumDigits);
        end else begin
            o_q_job.dot   = 1'b0;
            o_q_job.count = DigitIdxW'(r_cnt) + DigitIdxW'(2);
        end
    end

    // Hold open bytes, drop them when the group closes
    always_comb begin
        n_held = r_held;
        n_cnt  = r_cnt;
        if (accept) begin
            if (close) begin
                n_held = 24'd0;
                n_cnt  = 2'd0;
            end else begin
                n_held = {r_held[15:0], i_byte.data_byte};
                n_cnt  = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 24'd0;
            r_cnt  <= 2'd0;
        end else begin
            r_held <= n_held;
            r_cnt  <= n_cnt;
        end
    end

endmodule

@@ hw/rtl/b85se_queue.sv @@
// ----------------------------------------------------------------------------
// b85se_queue
// Small first-in first-out queue of conversion jobs between front and back.
// ----------------------------------------------------------------------------
module b85se_queue #(
    parameter int Depth = b85se_pkg::QueueDepthDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b85se_pkg::t_job   i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output b85se_pkg::t_job   o_job
);
    import b85se_pkg::*;

    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    t_job             r_mem [Depth];
    logic [AddrW-1:0] r_wr_ptr;
    logic [AddrW-1:0] r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AddrW'(Depth - 1)) ? '0 : r_wr_ptr + AddrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AddrW'(Depth - 1)) ? '0 : r_rd_ptr + AddrW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

    // A push never arrives while the queue is full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into a full queue");

    // Occupancy never exceeds the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(Depth))
        else $error("queue occupancy out of range");

endmodule

@@ hw/rtl/b85se_back.sv @@
// ----------------------------------------------------------------------------
// b85se_back
// Converts each job to base-85 digits with a shared divide-by-85 step, then
// serializes the characters most significant first onto the output channel.
// ----------------------------------------------------------------------------
module b85se_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  b85se_pkg::t_job   i_q_job,
    output logic              o_q_pop,
    b85se_char_if.source      o_char
);
    import b85se_pkg::*;

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StRun  = 2'd1;
    localparam logic [1:0] StDone = 2'd2;

    // Reciprocal of 85 for exact 32-bit quotients
    localparam logic [31:0] DivMagic = 32'hC0C0C0C1;
    localparam int          DivShift = 38;

    // Converter registers
    logic [1:0]           r_state;
    logic [DigitIdxW-1:0] r_step;
    logic [31:0]          r_val;
    logic [31:0]          r_prev;
    logic [6:0]           r_dig [NumDigits];
    logic [DigitIdxW-1:0] r_cnt;
    logic                 r_dot;
    logic                 r_eom;

    // Serializer registers
    logic                 r_ser_valid;
    logic [6:0]           r_chr [NumDigits];
    logic [DigitIdxW-1:0] r_ser_idx;
    logic [DigitIdxW-1:0] r_ser_cnt;
    logic                 r_ser_eom;

    logic [63:0]          prod;
    logic [31:0]          quot;
    logic [6:0]           rem;
    logic [DigitIdxW-1:0] dig_idx;
    logic                 ser_last;
    logic                 ser_take;
    logic                 ser_load;

    // Divide by 85 through the reciprocal
    assign prod = 64'(r_val) * 64'(DivMagic);
    assign quot = 32'(prod >> DivShift);

    // Remainder of the previous value, r_val being its quotient
    assign rem     = r_prev[6:0] - 7'(r_val[6:0] * 7'd85);
    assign dig_idx = DigitIdxW'(6) - r_step;

    // Serializer handshake
    assign ser_last = (r_ser_idx == r_ser_cnt - DigitIdxW'(1));
    assign ser_take = r_ser_valid && o_char.ready;
    assign ser_load = (r_state == StDone) && (!r_ser_valid || (ser_take && ser_last));

    assign o_q_pop = (r_state == StIdle) && i_q_valid;

    // Converter: load, five divide/remainder steps, then hand off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_step  <= '0;
        end else begin
            case (r_state)
                StIdle: begin
                    if (i_q_valid) begin
                        r_state <= StRun;
                        r_step  <= DigitIdxW'(1);
                    end
                end
                StRun: begin
                    if (r_step == DigitIdxW'(NumDigits)) begin
                        r_state <= StDone;
                    end
                    r_step <= r_step + DigitIdxW'(1);
                end
                StDone: begin
                    if (ser_load) begin
                        r_state <= StIdle;
                    end
                end
                default: begin
                    r_state <= StIdle;
                end
            endcase
        end
    end

    // Converter datapath
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_val <= i_q_job.word;
            r_cnt <= i_q_job.count;
            r_dot <= i_q_job.dot;
            r_eom <= i_q_job.eom;
        end else if (r_state == StRun) begin
            r_prev <= r_val;
            r_val  <= quot;
            if (r_step != DigitIdxW'(1)) begin
                r_dig[dig_idx] <= rem;
            end
            if (r_step == DigitIdxW'(NumDigits)) begin
                r_dig[0] <= r_val[6:0];
            end
        end
    end

    // Serializer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_ser_idx   <= '0;
        end else begin
            if (ser_load) begin
                r_ser_valid <= 1'b1;
                r_ser_idx   <= '0;
            end else if (ser_take) begin
                if (ser_last) begin
                    r_ser_valid <= 1'b0;
                end else begin
                    r_ser_idx <= r_ser_idx + DigitIdxW'(1);
                end
            end
        end
    end

    // Serializer payload: map digits to characters on hand-off
    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            for (int i = 0; i < NumDigits; i++) begin
                r_chr[i] <= (i == 0 && r_dot) ? DotChar : b85_char(r_dig[i]);
            end
            r_ser_cnt <= r_cnt;
            r_ser_eom <= r_eom;
        end
    end

    assign o_char.valid        = r_ser_valid;
    assign o_char.out_char     = r_chr[r_ser_idx];
    assign o_char.run_last     = ser_last;
    assign o_char.message_done = ser_last && r_ser_eom;

    // Every finished digit is a valid base-85 value
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StDone) |-> (r_dig[0] < 7'd85 && r_dig[1] < 7'd85 &&
            r_dig[2] < 7'd85 && r_dig[3] < 7'd85 && r_dig[4] < 7'd85))
        else $error("converted digit out of range");

    // The character index stays inside the group being sent
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ser_valid |-> (r_ser_idx < r_ser_cnt))
        else $error("serializer index past character count");

    // A load leaves the converter free on the next cycle
    a_load_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ser_load |=> (r_state == StIdle) && r_ser_valid)
        else $error("hand-off did not release the converter");

endmodule

@@ hw/rtl/base85_stream_encoder.sv @@
// The byte that closes a group pushes a job; the converter loads it, runs
// five divide-by-85 steps, hands off, and only then takes the next group.
// One character per cycle on the output while the output is ready.
// Bytes that only extend a group are taken every cycle while the queue has room.
// Reset: synchronous, active low; clears the held group, queue and output.
// ----------------------------------------------------------------------------
// base85_stream_encoder
// Byte stream to base-85 characters: front gathers groups, a job queue
// decouples it from the back, which converts and serializes.
// ----------------------------------------------------------------------------
module base85_stream_encoder #(
    parameter int QueueDepth = b85se_pkg::QueueDepthDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    b85se_byte_if.sink    i_byte,
    b85se_char_if.source  o_char
);
    import b85se_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_job q_in_job;
    t_job q_out_job;

    b85se_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_in_job)
    );

    b85se_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    b85se_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_out_job),
        .o_q_pop   (q_pop),
        .o_char    (o_char)
    );

endmodule
